### rtl/core/lmsf_pkg.sv
`default_nettype none

package lmsf_pkg;

	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int STEP_W    = 16;
	localparam int TAPS_W    = 6;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int W_BITS    = 32;
	localparam int W_FRAC    = 30;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 1'b1;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;
	localparam logic [TAPS_W-1:0] TAPS_RESET = 6'd8;

	// sequencer to datapath strobes
	typedef struct packed {
		logic acc_clr;
		logic dot_s1;
		logic upd_s1;
		logic round_go;
		logic err_go;
		logic warm;
		logic mu_go;
	} lmsf_ctl_t;

endpackage

`default_nettype wire

### rtl/core/lmsf_ram.sv
`default_nettype none

module lmsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd <= mem_q[ra];
	end

endmodule

`default_nettype wire

### rtl/core/lmsf_dp.sv
`default_nettype none

module lmsf_dp #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_TAPS    = 32,
	parameter int IDX_W       = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmsf_pkg::lmsf_ctl_t               ctl,
	input  logic [lmsf_pkg::W_BITS-1:0]       w_rd,
	input  logic                              w_ok,
	input  logic [SAMPLE_BITS-1:0]            h_rd,
	input  logic [IDX_W-1:0]                  rd_addr,
	input  logic signed [SAMPLE_BITS-1:0]     desired,
	input  logic [lmsf_pkg::STEP_W-1:0]       step,
	output logic                              w_we,
	output logic [IDX_W-1:0]                  w_wa,
	output logic [lmsf_pkg::W_BITS-1:0]       w_wd,
	output logic signed [SAMPLE_BITS-1:0]     y,
	output logic signed [SAMPLE_BITS:0]       e,
	output logic                              busy
);

	import lmsf_pkg::*;

	localparam int CL        = $clog2(MAX_TAPS);
	localparam int PROD_W    = W_BITS + SAMPLE_BITS;
	localparam int ACC_W     = PROD_W + CL + 1;
	localparam int YR_W      = ACC_W - W_FRAC + 1;
	localparam int MU_W      = STEP_W + SAMPLE_BITS + 2;
	localparam int UP_W      = MU_W + SAMPLE_BITS;
	localparam int UPD_SHIFT = 2 * SAMPLE_BITS - 17;
	localparam int RSH       = (UPD_SHIFT > 0) ? UPD_SHIFT : 0;
	localparam int LSH       = (UPD_SHIFT < 0) ? -UPD_SHIFT : 0;
	localparam int DL_W      = UP_W + LSH + 1;
	localparam int SUM_W     = DL_W + 1;

	localparam logic signed [ACC_W:0] ACC_RND = (ACC_W+1)'(1) << (W_FRAC - 1);
	localparam logic signed [DL_W-1:0] UPD_RND =
		(RSH > 0) ? (DL_W'(1) << ((RSH > 0) ? RSH - 1 : 0)) : DL_W'(0);

	localparam logic signed [YR_W-1:0]  Y_HI = YR_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [YR_W-1:0]  Y_LO = ~Y_HI;
	localparam logic signed [YR_W:0]    E_HI = (YR_W+1)'({1'b0, {SAMPLE_BITS{1'b1}}});
	localparam logic signed [YR_W:0]    E_LO = ~E_HI;
	localparam logic signed [SUM_W-1:0] W_HI = SUM_W'({1'b0, {(W_BITS-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] W_LO = ~W_HI;

	logic signed [W_BITS-1:0]      w_eff;
	logic signed [SAMPLE_BITS-1:0] h_s;

	logic                          dotv_s2, updv_s2, updv_s3;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [UP_W-1:0]        uprod_s2;
	logic signed [W_BITS-1:0]      w_s2, w_s3;
	logic [IDX_W-1:0]              a_s2, a_s3;
	logic signed [DL_W-1:0]        delta_s3;

	logic signed [ACC_W-1:0]       acc_q;
	logic signed [YR_W-1:0]        yr_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [SAMPLE_BITS:0]   e_q;
	logic signed [MU_W-1:0]        mu_e_q;

	logic signed [ACC_W:0]         acc_rnd;
	logic signed [YR_W:0]          diff;
	logic signed [DL_W-1:0]        up_ext;
	logic signed [SUM_W-1:0]       w_sum;

	assign w_eff = w_ok ? $signed(w_rd) : '0;
	assign h_s   = $signed(h_rd);

	assign acc_rnd = (ACC_W+1)'(acc_q) + ACC_RND;
	assign diff    = (YR_W+1)'(desired) - (YR_W+1)'(yr_q);
	assign up_ext  = DL_W'(uprod_s2) <<< LSH;
	assign w_sum   = SUM_W'(w_s3) + SUM_W'(delta_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dotv_s2 <= 1'b0;
			updv_s2 <= 1'b0;
			updv_s3 <= 1'b0;
		end else begin
			dotv_s2 <= ctl.dot_s1;
			updv_s2 <= ctl.upd_s1;
			updv_s3 <= updv_s2;
		end
	end

	always_ff @(posedge clk) begin
		// multiply stage
		prod_s2  <= w_eff * h_s;
		uprod_s2 <= mu_e_q * h_s;
		w_s2     <= w_eff;
		a_s2     <= rd_addr;

		// update: round the correction term
		delta_s3 <= (up_ext + UPD_RND) >>> RSH;
		w_s3     <= w_s2;
		a_s3     <= a_s2;

		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (dotv_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end

		if (ctl.round_go) begin
			yr_q <= acc_rnd[ACC_W:W_FRAC];
		end

		if (ctl.err_go) begin
			if (ctl.warm) begin
				y_q <= '0;
				e_q <= '0;
			end else begin
				y_q <= (yr_q > Y_HI) ? Y_HI[SAMPLE_BITS-1:0] :
				       (yr_q < Y_LO) ? Y_LO[SAMPLE_BITS-1:0] : yr_q[SAMPLE_BITS-1:0];
				e_q <= (diff > E_HI) ? E_HI[SAMPLE_BITS:0] :
				       (diff < E_LO) ? E_LO[SAMPLE_BITS:0] : diff[SAMPLE_BITS:0];
			end
		end

		if (ctl.mu_go) begin
			mu_e_q <= $signed({1'b0, step}) * e_q;
		end
	end

	assign w_we = updv_s3;
	assign w_wa = a_s3;
	assign w_wd = (w_sum > W_HI) ? W_HI[W_BITS-1:0] :
	              (w_sum < W_LO) ? W_LO[W_BITS-1:0] : w_sum[W_BITS-1:0];

	assign y    = y_q;
	assign e    = e_q;
	assign busy = dotv_s2 | updv_s2 | updv_s3;

endmodule

`default_nettype wire

### rtl/core/lms_adaptive_filter.sv
// LMS adaptive FIR filter, a serial multiply-accumulate datapath over weight and history RAMs.
// Each word runs a serial dot-product pass and weight-update pass through the weight and
//   history memories; during warm-up both passes are skipped. The next word is accepted
//   only after the result is loaded, so one word is in process at a time.
// Reset: async active low; weights read as zero, warm-up count cleared, registers default.
`default_nettype none

module lms_adaptive_filter #(
	parameter int MAX_TAPS    = lmsf_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = lmsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lmsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lmsf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  ref_sample,
	input  logic signed [SAMPLE_BITS-1:0]  desired_sample,
	input  logic                           start_block,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  filter_out,
	output logic signed [SAMPLE_BITS:0]    error_out
);

	import lmsf_pkg::*;

	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DOT  = 7'b0000010,
		S_RND  = 7'b0000100,
		S_ERR  = 7'b0001000,
		S_MU   = 7'b0010000,
		S_UPD  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [STEP_W-1:0]             step_q;
	logic [TAPS_W-1:0]             taps_q;
	logic [CNT_W-1:0]              taps_eff, cnt_eff, iss_q, wcnt_q;
	logic [IDX_W-1:0]              hptr_q, head_q, hist_last, hptr_dec;
	logic [MAX_TAPS-1:0]           wvalid_q;
	logic                          rd_v_q, rd_upd_q, warm_q, wok_q;
	logic [IDX_W-1:0]              rd_addr_q;
	logic [SAMPLE_BITS-1:0]        x_q;
	logic signed [SAMPLE_BITS-1:0] d_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filter_q;
	logic signed [SAMPLE_BITS:0]   error_q;

	logic accept, iss_more, issue, drained, out_free, done_fire;

	lmsf_ctl_t                     ctl;
	logic [W_BITS-1:0]             w_rd, w_wd;
	logic [SAMPLE_BITS-1:0]        h_rd;
	logic                          w_we, dp_busy;
	logic [IDX_W-1:0]              w_wa;
	logic signed [SAMPLE_BITS-1:0] dp_y;
	logic signed [SAMPLE_BITS:0]   dp_e;

	always_comb begin
		if (taps_q == '0) begin
			taps_eff = CNT_W'(1);
		end else if (int'(taps_q) > MAX_TAPS) begin
			taps_eff = CNT_W'(MAX_TAPS);
		end else begin
			taps_eff = CNT_W'(taps_q);
		end
	end

	assign cnt_eff   = start_block ? '0 : wcnt_q;
	assign hist_last = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign hptr_dec  = (hptr_q == '0) ? LAST_IDX : hptr_q - 1'b1;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign iss_more  = (iss_q < taps_eff);
	assign issue     = ((state_q == S_DOT) || (state_q == S_UPD)) && iss_more;
	assign drained   = !iss_more && !rd_v_q && !dp_busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign done_fire = (state_q == S_DONE) && out_free;

	always_comb begin
		ctl.acc_clr  = accept;
		ctl.dot_s1   = rd_v_q && !rd_upd_q;
		ctl.upd_s1   = rd_v_q && rd_upd_q;
		ctl.round_go = (state_q == S_RND);
		ctl.err_go   = (state_q == S_ERR);
		ctl.warm     = warm_q;
		ctl.mu_go    = (state_q == S_MU);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (cnt_eff < taps_eff) ? S_ERR : S_DOT;
				end
			end
			S_DOT: begin
				if (drained) begin
					state_d = S_RND;
				end
			end
			S_RND:  state_d = S_ERR;
			S_ERR:  state_d = warm_q ? S_DONE : S_MU;
			S_MU:   state_d = S_UPD;
			S_UPD: begin
				if (drained) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			taps_q <= TAPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_SIZE:   step_q <= cfg_data[STEP_W-1:0];
				REG_ACTIVE_TAPS: taps_q <= cfg_data[TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= '0;
			hptr_q      <= '0;
			head_q      <= '0;
			wcnt_q      <= '0;
			wvalid_q    <= '0;
			rd_v_q      <= 1'b0;
			rd_upd_q    <= 1'b0;
			warm_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_q   <= issue;
			rd_upd_q <= (state_q == S_UPD);

			if (accept) begin
				warm_q <= (cnt_eff < taps_eff);
				wcnt_q <= cnt_eff;
			end else if (done_fire && (wcnt_q != CNT_W'(MAX_TAPS))) begin
				wcnt_q <= wcnt_q + 1'b1;
			end

			if (accept || (state_q == S_MU)) begin
				iss_q  <= '0;
				hptr_q <= hist_last;
			end else if (issue) begin
				iss_q  <= iss_q + 1'b1;
				hptr_q <= hptr_dec;
			end

			// start flag drops all weights to zero at once
			if (accept && start_block) begin
				wvalid_q <= '0;
			end else if (w_we) begin
				wvalid_q[w_wa] <= 1'b1;
			end

			if (done_fire) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			end

			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= ref_sample;
			d_q <= desired_sample;
		end
		rd_addr_q <= iss_q[IDX_W-1:0];
		wok_q     <= wvalid_q[iss_q[IDX_W-1:0]];
		if (done_fire) begin
			filter_q <= dp_y;
			error_q  <= dp_e;
		end
	end

	lmsf_ram #(
		.WIDTH (W_BITS),
		.DEPTH (MAX_TAPS),
		.AW    (IDX_W)
	) u_wram (
		.clk (clk),
		.we  (w_we),
		.wa  (w_wa),
		.wd  (w_wd),
		.ra  (iss_q[IDX_W-1:0]),
		.rd  (w_rd)
	);

	lmsf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS),
		.AW    (IDX_W)
	) u_hram (
		.clk (clk),
		.we  (done_fire),
		.wa  (head_q),
		.wd  (x_q),
		.ra  (hptr_q),
		.rd  (h_rd)
	);

	lmsf_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_TAPS    (MAX_TAPS),
		.IDX_W       (IDX_W)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.w_rd    (w_rd),
		.w_ok    (wok_q),
		.h_rd    (h_rd),
		.rd_addr (rd_addr_q),
		.desired (d_q),
		.step    (step_q),
		.w_we    (w_we),
		.w_wa    (w_wa),
		.w_wd    (w_wd),
		.y       (dp_y),
		.e       (dp_e),
		.busy    (dp_busy)
	);

	assign out_valid  = out_valid_q;
	assign filter_out = filter_q;
	assign error_out  = error_q;

endmodule

`default_nettype wire

### rtl/core/lmsf_checker.sv
`default_nettype none

module lmsf_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] filter_out,
	input logic signed [SAMPLE_BITS:0]   error_out
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filter_out) && $stable(error_out))
		else $error("result word changed while stalled");

	// one word in flight: input side closes after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input accepted while a word is in process");

	// a new result only comes out of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a word in process");

endmodule

bind lms_adaptive_filter lmsf_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_lmsf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.filter_out (filter_out),
	.error_out  (error_out)
);

`default_nettype wire

### bench/lms_adaptive_filter_test.sv
`timescale 1ns / 100ps

module lms_adaptive_filter_test;
	import lmsf_pkg::*;

	localparam int MAX_TAPS        = MAX_TAPS_DEF;
	localparam int SB              = SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_WORDS     = 123;
	localparam int PHASES          = 10;
	localparam int SCRIPT_ROWS     = 25;
	localparam int SETTLE_CYCLES   = 100;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [SB-1:0]  ref_sample;
	logic signed [SB-1:0]  desired_sample;
	logic                  start_block;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [SB-1:0]  filter_out;
	logic signed [SB:0]    error_out;

	lms_adaptive_filter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ref_sample     (ref_sample),
		.desired_sample (desired_sample),
		.start_block    (start_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filter_out     (filter_out),
		.error_out      (error_out)
	);

	typedef struct packed {
		logic signed [SB-1:0] y;
		logic signed [SB:0]   e;
	} filter_result_t;

	typedef struct packed {
		logic signed [SB-1:0] x;
		logic signed [SB-1:0] d;
		logic                 start;
		logic                 known;
		logic signed [SB-1:0] y;
		logic signed [SB:0]   e;
	} script_row_t;

	filter_result_t filter_results_q[$];
	script_row_t    script [SCRIPT_ROWS];

	// shadow of the filter state
	longint tap_weights [MAX_TAPS];
	longint sample_line [MAX_TAPS];
	int     warm_count;
	int     mu_q16;
	int     order_reg;

	int  words_in;
	int  words_out;
	int  fail_count;
	int  idle_cycles;
	int  stall_left;
	int  hold_left;
	bit  no_idle;
	logic hold_req;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint round_shr(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic void clear_filter_state();
		for (int k = 0; k < MAX_TAPS; k++) begin
			tap_weights[k] = 0;
			sample_line[k] = 0;
		end
		warm_count = 0;
	endfunction

	function automatic filter_result_t lms_filter_step(input logic signed [SB-1:0] x,
			input logic signed [SB-1:0] d, input logic start);
		filter_result_t r;
		int     taps;
		longint acc;
		longint yr;
		longint err;
		longint p;
		r = '0;
		if (start)
			clear_filter_state();
		taps = order_reg;
		if (taps < 1)
			taps = 1;
		if (taps > MAX_TAPS)
			taps = MAX_TAPS;
		if (warm_count >= taps) begin
			acc = 0;
			for (int k = 0; k < taps; k++)
				acc += tap_weights[k] * sample_line[k];
			yr = round_shr(acc, W_FRAC);
			err = clip(longint'(d) - yr, SB + 1);
			r.y = SB'(clip(yr, SB));
			r.e = (SB + 1)'(err);
			for (int k = 0; k < taps; k++) begin
				p = longint'(mu_q16) * err * sample_line[k];
				tap_weights[k] = clip(tap_weights[k] + round_shr(p, 2 * SB - 17), W_BITS);
			end
		end
		for (int k = MAX_TAPS - 1; k > 0; k--)
			sample_line[k] = sample_line[k - 1];
		sample_line[0] = x;
		if (warm_count < MAX_TAPS)
			warm_count++;
		return r;
	endfunction

	function automatic int pick_wait();
		return no_idle ? 0 : int'($urandom_range(0, 15));
	endfunction

	task automatic send_word(input logic signed [SB-1:0] x, input logic signed [SB-1:0] d,
			input logic s, input logic known, input filter_result_t typed);
		int gap;
		filter_result_t r;
		gap = pick_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ref_sample     <= x;
		desired_sample <= d;
		start_block    <= s;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = lms_filter_step(x, d, s);
		filter_results_q.push_back(known ? typed : r);
		words_in++;
		@(negedge clk);
	endtask

	// drain every pending word so the block is idle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (filter_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_STEP_SIZE)
			mu_q16 = val & 16'hFFFF;
		else
			order_reg = val & 6'h3F;
	endtask

	// output side: random stall while a word is offered, plus one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req <= 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (out_valid && stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_out
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			stall_left = pick_wait();
			if (filter_results_q.size() == 0) begin
				$error("unrequested word: filter_out %0d error_out %0d", filter_out, error_out);
				fail_count++;
			end else begin
				want = filter_results_q.pop_front();
				if (filter_out !== want.y) begin
					$error("filter_out: expected %0d, got %0d", $signed(want.y), filter_out);
					fail_count++;
				end
				if (error_out !== want.e) begin
					$error("error_out: expected %0d, got %0d", $signed(want.e), error_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("FAIL lms_adaptive_filter");
		$finish;
	end

	initial begin
		filter_result_t typed_r;
		logic signed [SB-1:0] x;
		logic signed [SB-1:0] d;
		logic signed [SB-1:0] hist1;
		logic signed [SB-1:0] hist2;
		logic   s;
		longint acc;
		int     mu_v;
		int     taps_v;
		int     kind;
		int     plant [3];

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		ref_sample     = '0;
		desired_sample = '0;
		start_block    = 1'b0;
		no_idle        = 1'b0;
		hold_req       = 1'b0;
		hold_left      = 0;
		stall_left     = 0;
		words_in       = 0;
		words_out      = 0;
		fail_count     = 0;
		hist1          = '0;
		hist2          = '0;
		mu_q16         = STEP_RESET;
		order_reg      = TAPS_RESET;
		clear_filter_state();

		// x, d, start, known, y, e; reset order is 8 taps
		script = '{
			'{16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh0000, 16'sh0000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh0001, 16'shFFFF, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'shFFFF, 16'sh0001, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh4000, 16'shC000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh8000, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			// history full, weights still zero: e equals d
			'{16'sh3039, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sh18000},
			'{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 16'sd0, 17'sd0},
			'{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 16'sd0, 17'sd0},
			'{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 17'sd0},
			'{16'sh0000, 16'sh7FFF, 1'b0, 1'b0, 16'sd0, 17'sd0},
			'{16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 16'sd0, 17'sd0},
			'{16'shFFFF, 16'sh8000, 1'b0, 1'b0, 16'sd0, 17'sd0},
			// restart: warm-up again
			'{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 16'sd0, 17'sd0},
			'{16'sh8000, 16'sh0001, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh1234, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'shEDCC, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh0001, 16'sh0000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh8000, 16'sh8000, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh0100, 16'shFF00, 1'b0, 1'b1, 16'sd0, 17'sd0},
			'{16'sh2000, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 17'sh07FFF},
			'{16'shC000, 16'sh4000, 1'b0, 1'b0, 16'sd0, 17'sd0}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			typed_r.y = script[i].y;
			typed_r.e = script[i].e;
			send_word(script[i].x, script[i].d, script[i].start, script[i].known, typed_r);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			case (ph)
				0: begin mu_v = 65535; taps_v = 32; end
				1: begin mu_v = 0;     taps_v = 1;  end
				2: begin mu_v = 1;     taps_v = 0;  end
				3: begin mu_v = 328;   taps_v = 63; end
				4: begin mu_v = 16384; taps_v = 4;  end
				5: begin mu_v = 32768; taps_v = 33; end
				6: begin mu_v = 2000;  taps_v = 16; end
				9: begin mu_v = 65535; taps_v = 2;  end
				default: begin
					mu_v   = $urandom_range(0, 65535);
					taps_v = $urandom_range(0, 63);
				end
			endcase
			// no restart here: history carries over into the new order
			write_reg(REG_STEP_SIZE, mu_v);
			write_reg(REG_ACTIVE_TAPS, taps_v);
			no_idle = (ph == 2 || ph == 7);
			for (int k = 0; k < 3; k++)
				plant[k] = int'($urandom_range(0, 32767)) - 16384;

			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 3 && n == 40)
					hold_req <= 1'b1;
				if (ph == 5 && n == 60)
					quiesce();
				kind = $urandom_range(0, 9);
				case (kind)
					0:       x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					1, 2:    x = SB'($urandom);
					default: x = SB'($urandom_range(0, 8191) - 4096);
				endcase
				// mostly a fixed unknown plant so the weights have something to track
				kind = $urandom_range(0, 9);
				case (kind)
					7:       d = SB'($urandom);
					8:       d = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					9:       d = x;
					default: begin
						acc = longint'(plant[0]) * x + longint'(plant[1]) * hist1
							+ longint'(plant[2]) * hist2 + int'($urandom_range(0, 1023)) - 512;
						d = SB'(clip(acc >>> 15, SB));
					end
				endcase
				s = ($urandom_range(0, 79) == 0);
				hist2 = hist1;
				hist1 = x;
				send_word(x, d, s, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (filter_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d samples, %0d outputs checked, over step sizes 0..65535 and orders 0..63,",
			words_in, words_out);
		$display("with restarts, random gaps and stalls, and a long output hold-off.");
		if (fail_count == 0)
			$display("PASS lms_adaptive_filter");
		else
			$display("FAIL lms_adaptive_filter");
		$finish;
	end

endmodule
